### rtl/lfpa_pkg.sv
// ----------------------------------------------------------------------------
// Lidar frame parser package
// Shared types and constants for the nine-byte lidar frame parser and
// distance averager.
// ----------------------------------------------------------------------------
package lfpa_pkg;

  localparam int FRAME_LEN   = 9;
  localparam int FILL_W      = 4;
  localparam int BYTE_W      = 8;
  localparam int DIST_W      = 16;
  localparam int SUM_W       = 32;
  localparam int STEP_W      = 5;
  localparam int READING_W   = 17;
  localparam int STATUS_W    = 2;
  localparam int USED_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [BYTE_W-1:0]    HDR_BYTE   = 8'h59;
  localparam logic [BYTE_W-1:0]    SIG_MIN    = 8'd7;
  localparam logic [READING_W-1:0] OOR_ADD_CM = 17'd100;

  localparam logic [FILL_W-1:0] POS_EMPTY   = 4'd0;
  localparam logic [FILL_W-1:0] POS_HDR2    = 4'd1;
  localparam logic [FILL_W-1:0] POS_DIST_LO = 4'd2;
  localparam logic [FILL_W-1:0] POS_DIST_HI = 4'd3;
  localparam logic [FILL_W-1:0] POS_SIG     = 4'd6;
  localparam logic [FILL_W-1:0] POS_CSUM    = FILL_W'(FRAME_LEN - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODEL_MAX = 2'd0,
    CFG_USER_MAX  = 2'd1,
    CFG_SIG_EN    = 2'd2
  } lfpa_cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_AVG  = 2'd0,
    STATUS_OOR  = 2'd1,
    STATUS_NONE = 2'd2
  } lfpa_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } lfpa_state_t;

  typedef struct packed {
    logic take_byte;
    logic start_poll;
    logic load_direct;
    logic div_step;
    logic load_div;
  } lfpa_cmd_t;

  typedef struct packed {
    logic have_good;
    logic div_last;
    logic out_valid;
  } lfpa_stat_t;

endpackage

### rtl/lfpa_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Carries received bytes and poll requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfpa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lfpa_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

### rtl/lfpa_out_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Carries one poll result with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfpa_out_if;
  logic                           valid;
  logic                           ready;
  logic [lfpa_pkg::READING_W-1:0] reading_cm;
  logic [lfpa_pkg::STATUS_W-1:0]  status;
  logic [lfpa_pkg::USED_W-1:0]    frames_used;

  modport source (output valid, output reading_cm, output status, output frames_used,
                  input ready);
  modport sink (input valid, input reading_cm, input status, input frames_used,
                output ready);
endinterface

### rtl/lfpa_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write interface
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfpa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lfpa_pkg::CFG_IDX_W-1:0]  index;
  logic [lfpa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/lidar_frame_parser_averager.sv
// ----------------------------------------------------------------------------
// Lidar frame parser and distance averager
// Parses nine-byte lidar frames from received bytes and returns an averaged
// distance on each poll, or an out-of-range or empty result if none was good.
// ----------------------------------------------------------------------------
// A received byte is accepted in every cycle while the controller is idle. A poll
// that finds no good frame returns its result in the cycle after the transfer.
// A poll with good frames runs the sum through a restoring divider, one quotient
// bit per cycle, and its result is registered after the divide and load states;
// the input takes nothing in the meantime. A poll waits at the input while an
// earlier result has not yet been taken; bytes are never held back by the output.
module lidar_frame_parser_averager #(
  parameter int COUNT_WIDTH = 16
) (
  input logic          clk,
  input logic          rst,
  lfpa_in_if.sink      sample,
  lfpa_out_if.source   result,
  lfpa_cfg_if.sink     cfg
);

  lfpa_pkg::lfpa_cmd_t  cmd;
  lfpa_pkg::lfpa_stat_t stat;
  logic                 in_ready;
  logic                 out_valid;

  assign sample.ready = in_ready;
  assign result.valid = out_valid;
  assign cfg.ready    = 1'b1;

  lfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_kind   (sample.kind),
    .out_ready (result.ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  lfpa_dp #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .rx_byte     (sample.rx_byte),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .out_ready   (result.ready),
    .out_valid   (out_valid),
    .reading_cm  (result.reading_cm),
    .status      (result.status),
    .frames_used (result.frames_used)
  );

endmodule

### rtl/lfpa_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Divides the distance sum by the good frame count, one quotient bit per step.
// ----------------------------------------------------------------------------
module lfpa_div #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         step,
  input  logic [lfpa_pkg::SUM_W-1:0]   dividend,
  input  logic [COUNT_WIDTH-1:0]       divisor,
  output logic [lfpa_pkg::SUM_W-1:0]   quotient,
  output logic [COUNT_WIDTH-1:0]       divisor_hold,
  output logic                         last
);

  logic [lfpa_pkg::STEP_W-1:0] count;
  logic [COUNT_WIDTH-1:0]      rem;
  logic [COUNT_WIDTH:0]        shifted;
  logic                        fits;

  assign shifted = {rem, quotient[lfpa_pkg::SUM_W-1]};
  assign fits    = shifted >= {1'b0, divisor_hold};
  assign last    = count == {lfpa_pkg::STEP_W{1'b1}};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= '0;
    end else if (step) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem          <= '0;
      quotient     <= dividend;
      divisor_hold <= divisor;
    end else if (step) begin
      if (fits) begin
        rem <= COUNT_WIDTH'(shifted - {1'b0, divisor_hold});
      end else begin
        rem <= shifted[COUNT_WIDTH-1:0];
      end
      quotient <= {quotient[lfpa_pkg::SUM_W-2:0], fits};
    end
  end

endmodule

### rtl/lfpa_dp.sv
// ----------------------------------------------------------------------------
// Frame parser datapath
// Holds configuration, framing and accumulator registers, the divider and
// the result register.
// ----------------------------------------------------------------------------
module lfpa_dp #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lfpa_pkg::lfpa_cmd_t               cmd,
  output lfpa_pkg::lfpa_stat_t              stat,
  input  logic [lfpa_pkg::BYTE_W-1:0]       rx_byte,
  input  logic                              cfg_valid,
  input  logic [lfpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [lfpa_pkg::READING_W-1:0]    reading_cm,
  output logic [lfpa_pkg::STATUS_W-1:0]     status,
  output logic [lfpa_pkg::USED_W-1:0]       frames_used
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [lfpa_pkg::DIST_W-1:0]  model_max_cm;
  logic [lfpa_pkg::DIST_W-1:0]  user_max_cm;
  logic                         signal_byte_enable;

  logic [lfpa_pkg::FILL_W-1:0]  fill_count;
  logic [lfpa_pkg::BYTE_W-1:0]  running_checksum;
  logic [lfpa_pkg::BYTE_W-1:0]  dist_lo;
  logic [lfpa_pkg::BYTE_W-1:0]  dist_hi;
  logic [lfpa_pkg::BYTE_W-1:0]  sig_byte;
  logic [lfpa_pkg::SUM_W-1:0]   distance_sum;
  logic [COUNT_WIDTH-1:0]       good_count;
  logic [COUNT_WIDTH-1:0]       out_of_range_count;

  logic [lfpa_pkg::DIST_W-1:0]  dist_cm;
  logic [lfpa_pkg::SUM_W:0]     sum_wide;
  logic                         frame_end;
  logic                         frame_ok;
  logic                         frame_bad;
  logic                         add_good;
  logic                         add_oor;
  logic [lfpa_pkg::READING_W-1:0] user_limit;
  logic [lfpa_pkg::READING_W-1:0] oor_reading;

  logic [lfpa_pkg::SUM_W-1:0]   quotient;
  logic [COUNT_WIDTH-1:0]       divisor_hold;
  logic                         div_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_max_cm       <= '0;
      user_max_cm        <= '0;
      signal_byte_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lfpa_pkg::CFG_MODEL_MAX: model_max_cm       <= cfg_data;
        lfpa_pkg::CFG_USER_MAX:  user_max_cm        <= cfg_data;
        lfpa_pkg::CFG_SIG_EN:    signal_byte_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign dist_cm   = {dist_hi, dist_lo};
  assign frame_end = cmd.take_byte && (fill_count == lfpa_pkg::POS_CSUM);
  assign frame_ok  = running_checksum == rx_byte;
  assign frame_bad = dist_cm[lfpa_pkg::DIST_W-1] || (dist_cm == model_max_cm) ||
                     (signal_byte_enable && (sig_byte < lfpa_pkg::SIG_MIN));
  assign add_good  = frame_end && frame_ok && !frame_bad && (good_count != COUNT_MAX);
  assign add_oor   = frame_end && frame_ok && frame_bad &&
                     (out_of_range_count != COUNT_MAX);
  assign sum_wide  = {1'b0, distance_sum} + (lfpa_pkg::SUM_W + 1)'(dist_cm);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count       <= '0;
      running_checksum <= '0;
    end else if (cmd.take_byte) begin
      case (fill_count)
        lfpa_pkg::POS_EMPTY: begin
          if (rx_byte == lfpa_pkg::HDR_BYTE) begin
            fill_count       <= lfpa_pkg::POS_HDR2;
            running_checksum <= rx_byte;
          end else begin
            running_checksum <= '0;
          end
        end
        lfpa_pkg::POS_HDR2: begin
          if (rx_byte == lfpa_pkg::HDR_BYTE) begin
            fill_count       <= lfpa_pkg::POS_DIST_LO;
            running_checksum <= running_checksum + rx_byte;
          end else begin
            fill_count       <= '0;
            running_checksum <= '0;
          end
        end
        lfpa_pkg::POS_CSUM: begin
          fill_count       <= '0;
          running_checksum <= '0;
        end
        default: begin
          fill_count       <= fill_count + 1'b1;
          running_checksum <= running_checksum + rx_byte;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (fill_count == lfpa_pkg::POS_DIST_LO) begin
        dist_lo <= rx_byte;
      end
      if (fill_count == lfpa_pkg::POS_DIST_HI) begin
        dist_hi <= rx_byte;
      end
      if (fill_count == lfpa_pkg::POS_SIG) begin
        sig_byte <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start_poll) begin
      distance_sum       <= '0;
      good_count         <= '0;
      out_of_range_count <= '0;
    end else begin
      if (add_good) begin
        good_count <= good_count + 1'b1;
        if (sum_wide[lfpa_pkg::SUM_W]) begin
          distance_sum <= '1;
        end else begin
          distance_sum <= sum_wide[lfpa_pkg::SUM_W-1:0];
        end
      end
      if (add_oor) begin
        out_of_range_count <= out_of_range_count + 1'b1;
      end
    end
  end

  lfpa_div #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .start        (cmd.start_poll),
    .step         (cmd.div_step),
    .dividend     (distance_sum),
    .divisor      (good_count),
    .quotient     (quotient),
    .divisor_hold (divisor_hold),
    .last         (div_last)
  );

  assign user_limit  = {1'b0, user_max_cm} + lfpa_pkg::OOR_ADD_CM;
  assign oor_reading = ({1'b0, model_max_cm} > user_limit) ? {1'b0, model_max_cm}
                                                           : user_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_direct || cmd.load_div) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      reading_cm  <= quotient[lfpa_pkg::READING_W-1:0];
      status      <= lfpa_pkg::STATUS_AVG;
      frames_used <= lfpa_pkg::USED_W'(divisor_hold);
    end else if (cmd.load_direct) begin
      frames_used <= '0;
      if (out_of_range_count != '0) begin
        reading_cm <= oor_reading;
        status     <= lfpa_pkg::STATUS_OOR;
      end else begin
        reading_cm <= '0;
        status     <= lfpa_pkg::STATUS_NONE;
      end
    end
  end

  assign stat.have_good = good_count != '0;
  assign stat.div_last  = div_last;
  assign stat.out_valid = out_valid;

endmodule

### rtl/lfpa_ctrl.sv
// ----------------------------------------------------------------------------
// Frame parser controller
// Sequences byte transfers, polls and the divide steps of a poll.
// ----------------------------------------------------------------------------
module lfpa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_kind,
  input  logic                  out_ready,
  input  lfpa_pkg::lfpa_stat_t  stat,
  output logic                  in_ready,
  output lfpa_pkg::lfpa_cmd_t   cmd
);

  lfpa_pkg::lfpa_state_t state;
  lfpa_pkg::lfpa_state_t state_next;
  logic                  accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      lfpa_pkg::ST_IDLE: begin
        if (accept && in_kind && stat.have_good) begin
          state_next = lfpa_pkg::ST_DIV;
        end
      end
      lfpa_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_next = lfpa_pkg::ST_LOAD;
        end
      end
      lfpa_pkg::ST_LOAD: state_next = lfpa_pkg::ST_IDLE;
      default: state_next = lfpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      lfpa_pkg::ST_IDLE: begin
        in_ready        = !in_kind || !stat.out_valid || out_ready;
        cmd.take_byte   = accept && !in_kind;
        cmd.start_poll  = accept && in_kind;
        cmd.load_direct = accept && in_kind && !stat.have_good;
      end
      lfpa_pkg::ST_DIV:  cmd.div_step = 1'b1;
      lfpa_pkg::ST_LOAD: cmd.load_div = 1'b1;
      default: ;
    endcase
  end

endmodule

### tb/lfpa_poll_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Poll result checker for the lidar frame parser
// Watches the configuration, sample and result channels and keeps its own copy
// of the framing state and the distance accumulators. Every accepted poll
// yields a predicted reading. Every result transfer is compared field by field
// with the oldest predicted reading. Mismatches are counted for the top level.
// ----------------------------------------------------------------------------
module lfpa_poll_checker
  import lfpa_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  smp_valid,
  input  logic                  smp_ready,
  input  logic                  smp_kind,
  input  logic [BYTE_W-1:0]     smp_byte,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  logic [READING_W-1:0]  res_reading,
  input  logic [STATUS_W-1:0]   res_status,
  input  logic [USED_W-1:0]     res_used,
  output int                    pending,
  output int                    fail_count
);

  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  typedef struct packed {
    logic [READING_W-1:0] reading_cm;
    lfpa_status_t         status;
    logic [USED_W-1:0]    frames_used;
  } poll_reading_t;

  poll_reading_t     readings_due[$];

  logic [DIST_W-1:0] model_max;
  logic [DIST_W-1:0] user_max;
  logic              sig_check;

  logic [FILL_W-1:0] fill;
  logic [BYTE_W-1:0] frame [FRAME_LEN];
  logic [BYTE_W-1:0] csum;
  logic [SUM_W-1:0]  dist_sum;
  logic [31:0]       good_frames;
  logic [31:0]       oor_frames;
  int                errors = 0;

  task automatic report_error(input string msg);
    errors++;
    $display("%0t ns: %s", $time, msg);
  endtask

  function void score_frame();
    logic [DIST_W-1:0] dist_cm;
    logic              bad;
    if (csum != frame[POS_CSUM]) return;
    dist_cm = {frame[POS_DIST_HI], frame[POS_DIST_LO]};
    bad     = dist_cm[DIST_W-1] || (dist_cm == model_max);
    if (!bad && sig_check && (frame[POS_SIG] < SIG_MIN)) bad = 1'b1;
    if (bad) begin
      if (oor_frames < COUNT_MAX) oor_frames++;
      return;
    end
    if (good_frames >= COUNT_MAX) return;
    good_frames++;
    if (dist_sum > ({SUM_W{1'b1}} - SUM_W'(dist_cm))) begin
      dist_sum = {SUM_W{1'b1}};
    end else begin
      dist_sum = dist_sum + SUM_W'(dist_cm);
    end
  endfunction

  function void keep_byte(input logic [BYTE_W-1:0] c);
    if (fill >= FILL_W'(FRAME_LEN)) begin
      fill = POS_EMPTY;
      csum = '0;
      return;
    end
    frame[fill] = c;
    if (fill < POS_CSUM) csum = csum + c;
    fill = fill + 1'b1;
  endfunction

  function void absorb_byte(input logic [BYTE_W-1:0] c);
    if (fill == POS_EMPTY) begin
      csum = '0;
      if (c == HDR_BYTE) keep_byte(c);
    end else if (fill == POS_HDR2) begin
      if (c == HDR_BYTE) begin
        keep_byte(c);
      end else begin
        fill = POS_EMPTY;
        csum = '0;
      end
    end else begin
      keep_byte(c);
      if (fill == FILL_W'(FRAME_LEN)) begin
        score_frame();
        fill = POS_EMPTY;
        csum = '0;
      end
    end
  endfunction

  function poll_reading_t average_poll();
    poll_reading_t        r;
    logic [READING_W-1:0] floor_cm;
    if (good_frames != 0) begin
      r.reading_cm  = READING_W'(dist_sum / good_frames);
      r.status      = STATUS_AVG;
      r.frames_used = USED_W'(good_frames);
    end else if (oor_frames != 0) begin
      floor_cm      = READING_W'(user_max) + OOR_ADD_CM;
      r.reading_cm  = (READING_W'(model_max) > floor_cm) ? READING_W'(model_max) : floor_cm;
      r.status      = STATUS_OOR;
      r.frames_used = '0;
    end else begin
      r.reading_cm  = '0;
      r.status      = STATUS_NONE;
      r.frames_used = '0;
    end
    dist_sum    = '0;
    good_frames = '0;
    oor_frames  = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    poll_reading_t want;
    if (rst) begin
      readings_due.delete();
      model_max   = '0;
      user_max    = '0;
      sig_check   = 1'b0;
      fill        = POS_EMPTY;
      csum        = '0;
      dist_sum    = '0;
      good_frames = '0;
      oor_frames  = '0;
      for (int i = 0; i < FRAME_LEN; i++) frame[i] = '0;
    end else begin
      if (res_valid && res_ready) begin
        if (readings_due.size() == 0) begin
          report_error($sformatf("result transfer with no poll waiting: reading_cm %0d",
                                 res_reading));
        end else begin
          want = readings_due.pop_front();
          if (res_reading !== want.reading_cm)
            report_error($sformatf("reading_cm mismatch: got %0d, expected %0d",
                                   res_reading, want.reading_cm));
          if (res_status !== want.status)
            report_error($sformatf("status mismatch: got %0d, expected %0d",
                                   res_status, want.status));
          if (res_used !== want.frames_used)
            report_error($sformatf("frames_used mismatch: got %0d, expected %0d",
                                   res_used, want.frames_used));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODEL_MAX: model_max = cfg_data;
          CFG_USER_MAX:  user_max  = cfg_data;
          CFG_SIG_EN:    sig_check = cfg_data[0];
          default: ;
        endcase
      end
      if (smp_valid && smp_ready) begin
        if (smp_kind) begin
          readings_due.push_back(average_poll());
        end else begin
          absorb_byte(smp_byte);
        end
      end
    end
    pending    <= readings_due.size();
    fail_count <= errors;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench top for the lidar frame parser and averager
// Drives received bytes, polls and register writes into the block and lets
// the poll checker predict and compare every reading. A short directed part
// is followed by phases of mostly well-formed random frames under different
// register settings and idle patterns, and a long result back-pressure
// stretch.
// ----------------------------------------------------------------------------
module tb_top
  import lfpa_pkg::*;
;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 170;
  localparam int PHASE_POLLS   = 12;

  logic clk = 1'b0;
  logic rst;

  lfpa_in_if  sample_if ();
  lfpa_out_if result_if ();
  lfpa_cfg_if cfg_if ();

  int pending;
  int fail_count;
  int cycle_count = 0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_len     = 0;
  int items_sent   = 0;
  int polls_sent   = 0;
  logic [DIST_W-1:0] cur_model_max = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lidar_frame_parser_averager #(
    .COUNT_WIDTH (16)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  lfpa_poll_checker #(
    .COUNT_WIDTH (16)
  ) poll_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_index   (cfg_if.index),
    .cfg_data    (cfg_if.data),
    .smp_valid   (sample_if.valid),
    .smp_ready   (sample_if.ready),
    .smp_kind    (sample_if.kind),
    .smp_byte    (sample_if.rx_byte),
    .res_valid   (result_if.valid),
    .res_ready   (result_if.ready),
    .res_reading (result_if.reading_cm),
    .res_status  (result_if.status),
    .res_used    (result_if.frames_used),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The result side stalls at random, or holds off completely while a
  // requested hold-off is still counting down.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        result_if.ready <= 1'b0;
        hold_len = hold_len - 1;
      end else begin
        result_if.ready <= (int'($urandom_range(99)) >= rx_stall_pct);
      end
    end
  end

  task automatic offer(input logic kind, input logic [BYTE_W-1:0] b);
    int gap;
    gap = 0;
    while (gap < 24 && int'($urandom_range(99)) < tx_idle_pct) gap++;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid   <= 1'b1;
    sample_if.kind    <= kind;
    sample_if.rx_byte <= b;
    do @(posedge clk); while (!sample_if.ready);
    items_sent++;
  endtask

  task automatic poll();
    offer(1'b1, 8'($urandom_range(255)));
    polls_sent++;
  endtask

  task automatic send_frame(input logic [DIST_W-1:0] dist_cm, input logic [BYTE_W-1:0] sig,
                            input bit csum_ok, input int poll_at);
    logic [BYTE_W-1:0] b [FRAME_LEN];
    logic [BYTE_W-1:0] sum;
    int                i;
    b[0] = HDR_BYTE;
    b[1] = HDR_BYTE;
    b[2] = dist_cm[7:0];
    b[3] = dist_cm[15:8];
    b[4] = 8'($urandom_range(255));
    b[5] = 8'($urandom_range(255));
    b[6] = sig;
    b[7] = 8'($urandom_range(255));
    sum  = '0;
    for (i = 0; i < FRAME_LEN - 1; i++) sum = sum + b[i];
    b[FRAME_LEN-1] = csum_ok ? sum : (sum ^ 8'($urandom_range(255, 1)));
    for (i = 0; i < FRAME_LEN; i++) begin
      if (i == poll_at) poll();
      offer(1'b0, b[i]);
    end
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] mm, input logic [CFG_DATA_W-1:0] um,
                            input logic [CFG_DATA_W-1:0] sig_word);
    lfpa_cfg_idx_t           idx [3];
    logic [CFG_DATA_W-1:0]   val [3];
    int                      k;
    idx[0] = CFG_MODEL_MAX;
    idx[1] = CFG_USER_MAX;
    idx[2] = CFG_SIG_EN;
    val[0] = mm;
    val[1] = um;
    val[2] = sig_word;
    cur_model_max = mm;
    cfg_if.valid <= 1'b1;
    for (k = 0; k < 3; k++) begin
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering, wait for every pending reading, then let the block go quiet.
  task automatic settle();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(input int n_items, input int n_polls);
    int                item_stop;
    int                poll_stop;
    int                pick;
    logic [DIST_W-1:0] dist_cm;
    logic [BYTE_W-1:0] sig;
    item_stop = items_sent + n_items;
    poll_stop = polls_sent + n_polls;
    while (items_sent < item_stop || polls_sent < poll_stop) begin
      pick = int'($urandom_range(99));
      if (pick < 55) begin
        case ($urandom_range(5))
          0:       dist_cm = 16'($urandom_range(300));
          1:       dist_cm = 16'($urandom_range(32767));
          2:       dist_cm = cur_model_max;
          3:       dist_cm = 16'($urandom_range(65535, 32768));
          4:       dist_cm = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h0000;
          default: dist_cm = 16'($urandom);
        endcase
        sig = ($urandom_range(3) == 0) ? 8'($urandom_range(6)) : 8'($urandom_range(255));
        send_frame(dist_cm, sig, $urandom_range(9) != 0,
                   ($urandom_range(9) == 0) ? int'($urandom_range(FRAME_LEN - 1)) : FRAME_LEN);
      end else if (pick < 85) begin
        poll();
      end else if (pick < 93) begin
        offer(1'b0, ($urandom_range(1) != 0) ? HDR_BYTE : 8'($urandom_range(255)));
      end else begin
        offer(1'b0, HDR_BYTE);
        offer(1'b0, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    sample_if.valid   = 1'b0;
    sample_if.kind    = 1'b0;
    sample_if.rx_byte = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_MODEL_MAX;
    cfg_if.data       = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset register values.
    poll();
    send_frame(16'h7FFF, 8'hFF, 1'b1, 4);
    poll();
    send_frame(16'h8000, 8'h00, 1'b1, FRAME_LEN);
    poll();
    send_frame(16'h0000, 8'h10, 1'b1, FRAME_LEN);
    offer(1'b0, HDR_BYTE);
    offer(1'b0, 8'h00);
    poll();
    settle();

    set_config(16'($urandom), 16'($urandom), 16'($urandom) | 16'h0001);
    random_traffic(PHASE_ITEMS, PHASE_POLLS);
    settle();

    tx_idle_pct = 64;
    set_config(16'hFFFF, 16'hFFFF, 16'($urandom) & 16'hFFFE);
    random_traffic(PHASE_ITEMS, PHASE_POLLS);
    settle();

    tx_idle_pct  = 0;
    rx_stall_pct = 64;
    set_config(16'h0000, 16'hFFFF, 16'h0001);
    hold_len = 600;
    repeat (4) begin
      send_frame(16'($urandom_range(32767, 1)), 8'd200, 1'b1, FRAME_LEN);
      poll();
    end
    random_traffic(PHASE_ITEMS, PHASE_POLLS);
    settle();

    tx_idle_pct  = 36;
    rx_stall_pct = 36;
    set_config(16'($urandom), 16'($urandom), 16'($urandom));
    random_traffic(PHASE_ITEMS, PHASE_POLLS);
    settle();

    sample_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### lidar_frame_parser_averager.f
rtl/lfpa_pkg.sv
rtl/lfpa_in_if.sv
rtl/lfpa_out_if.sv
rtl/lfpa_cfg_if.sv
rtl/lfpa_div.sv
rtl/lfpa_dp.sv
rtl/lfpa_ctrl.sv
rtl/lidar_frame_parser_averager.sv
tb/lfpa_poll_checker.sv
tb/tb_top.sv
